// ===== hdl/rtp_receiver_statistics_defines.svh =====
// Assertion macros used by the port-level checker of the RTP receiver statistics block.
// Depends on nothing; the including module must have i_clk and i_rst_n in scope.
`ifndef RTP_RECEIVER_STATISTICS_DEFINES_SVH
`define RTP_RECEIVER_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPRS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/rtprs_pkg.sv =====
// Types, constants and codes of the RTP receiver statistics block.
// Used by every module of the block; depends on nothing.
package rtprs_pkg;

    localparam logic [15:0] DROPOUT_RESET  = 16'd3000;
    localparam logic [15:0] MISORDER_RESET = 16'd100;
    localparam logic [16:0] SEQ_MOD        = 17'h10000;
    localparam logic [16:0] BAD_SEQ_NONE   = 17'h10001;
    localparam logic [23:0] LOST_CLAMP     = 24'hffffff;
    localparam logic [31:0] JIT_ROUND      = 32'd8;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic REG_DROPOUT  = 1'b0;
    localparam logic REG_MISORDER = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] seq_number;
        logic [31:0] rtp_timestamp;
        logic [31:0] arrival_time;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [31:0] ext_highest;
        logic [23:0] cumulative_lost;
        logic [7:0]  fraction_lost;
        logic [27:0] jitter_out;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PKT_SEQ,
        S_PKT_DIFF,
        S_PKT_MAG,
        S_PKT_ACC,
        S_REP_EXP,
        S_REP_LOST,
        S_REP_INT,
        S_REP_DIV,
        S_REP_WAIT,
        S_FINISH
    } t_state;

    // Step strobes for the jitter estimator.
    typedef struct packed {
        logic load;
        logic diff;
        logic mag;
        logic commit;
    } t_jit_ctl;

    // Sequence tracking state as seen by the report path.
    typedef struct packed {
        logic [31:0] ext_max;
        logic [31:0] seq_origin;
        logic [31:0] received;
        logic [31:0] prior_expected;
        logic [31:0] prior_received;
    } t_seq_stats;

endpackage

// ===== hdl/rtp_receiver_statistics.sv =====
// RTP receiver statistics: between acceptance and the next acceptance a packet request
// runs four arithmetic steps plus accept and result hand-off; a report request runs its
// subtract steps and, when the fraction lost needs it, the bit-serial divider.
// The result register lets the next request in while a result waits to be taken.
// i_rst_n is synchronous and active low; it restores the RFC 3550 start state and
// the register defaults (dropout limit 3000, misorder limit 100). No clearing pass.
module rtp_receiver_statistics
    import rtprs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. The register index is taken from paddr[2], so each
    // register occupies one 32-bit word.
    logic [15:0] r_dropout_lim;
    logic [15:0] r_misorder_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropout_lim  <= DROPOUT_RESET;
            r_misorder_lim <= MISORDER_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_DROPOUT:  r_dropout_lim  <= pwdata[15:0];
                REG_MISORDER: r_misorder_lim <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'b0, (paddr[2] == REG_MISORDER) ? r_misorder_lim : r_dropout_lim};

    // Control state and the latched request.
    t_state      r_state, n_state;
    t_in_item    r_in;
    t_out_item   r_out;
    logic        r_out_valid;

    // Report datapath registers, one subtract level per cycle.
    logic [31:0] r_expected;
    logic [31:0] r_lost;
    logic [31:0] r_exp_int;
    logic [31:0] r_rec_int;
    logic [31:0] r_lost_int;
    logic [7:0]  r_frac;

    // Sequencer outputs.
    logic        w_in_ready;
    logic        w_seq_commit;
    logic        w_rep_commit;
    logic        w_div_start;
    logic        w_out_load;
    t_jit_ctl    w_jit_ctl;

    // Submodule outputs.
    t_seq_stats  w_stats;
    logic        w_accepted;
    logic        w_restart;
    logic [27:0] w_jitter;
    logic        w_div_done;
    logic [7:0]  w_div_quot;

    logic        w_frac_zero;
    t_out_item   w_result;

    // The fraction is zero without dividing when the interval expected is zero or
    // the interval loss is not a positive 32-bit signed value.
    assign w_frac_zero = (r_exp_int == 32'd0) || (r_lost_int == 32'd0) || r_lost_int[31];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.opcode == OP_REPORT) ? S_REP_EXP : S_PKT_SEQ;
                end
            end
            S_PKT_SEQ:  n_state = S_PKT_DIFF;
            S_PKT_DIFF: n_state = S_PKT_MAG;
            S_PKT_MAG:  n_state = S_PKT_ACC;
            S_PKT_ACC:  n_state = S_FINISH;
            S_REP_EXP:  n_state = S_REP_LOST;
            S_REP_LOST: n_state = S_REP_INT;
            S_REP_INT:  n_state = S_REP_DIV;
            S_REP_DIV:  n_state = w_frac_zero ? S_FINISH : S_REP_WAIT;
            S_REP_WAIT: begin
                if (w_div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready     = 1'b0;
        w_seq_commit   = 1'b0;
        w_rep_commit   = 1'b0;
        w_div_start    = 1'b0;
        w_out_load     = 1'b0;
        w_jit_ctl      = '0;
        case (r_state)
            S_IDLE:     w_in_ready = 1'b1;
            S_PKT_SEQ: begin
                w_seq_commit   = 1'b1;
                w_jit_ctl.load = 1'b1;
            end
            S_PKT_DIFF: w_jit_ctl.diff   = 1'b1;
            S_PKT_MAG:  w_jit_ctl.mag    = 1'b1;
            S_PKT_ACC:  w_jit_ctl.commit = 1'b1;
            S_REP_LOST: w_rep_commit = 1'b1;
            S_REP_DIV:  w_div_start  = !w_frac_zero;
            S_FINISH:   w_out_load   = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Report arithmetic. Reports never change the sequence counters; the interval counters
    // they update are read in S_REP_LOST before the update lands, so the inputs stay stable.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_state == S_REP_EXP) begin
            r_expected <= w_stats.ext_max - w_stats.seq_origin;
        end
        if (r_state == S_REP_LOST) begin
            r_lost    <= r_expected - w_stats.received;
            r_exp_int <= r_expected - w_stats.prior_expected;
            r_rec_int <= w_stats.received - w_stats.prior_received;
        end
        if (r_state == S_REP_INT) begin
            r_lost_int <= r_exp_int - r_rec_int;
        end
        if (r_state == S_REP_DIV) begin
            r_frac <= '0;
        end else if ((r_state == S_REP_WAIT) && w_div_done) begin
            r_frac <= w_div_quot;
        end
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    // A packet result carries only the accept flag; a report carries everything else.
    always_comb begin
        w_result = '0;
        if (r_in.opcode == OP_PACKET) begin
            w_result.accepted = w_accepted;
        end else begin
            w_result.ext_highest     = w_stats.ext_max;
            w_result.cumulative_lost = (|r_lost[31:24]) ? LOST_CLAMP : r_lost[23:0];
            w_result.fraction_lost   = r_frac;
            w_result.jitter_out      = w_jitter;
        end
    end

    rtprs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_commit       (w_seq_commit),
        .i_seq          (r_in.seq_number),
        .i_dropout_lim  (r_dropout_lim),
        .i_misorder_lim (r_misorder_lim),
        .i_rep_commit   (w_rep_commit),
        .i_rep_expected (r_expected),
        .o_stats        (w_stats),
        .o_accepted     (w_accepted),
        .o_restart      (w_restart)
    );

    rtprs_jitter u_jitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_jit_ctl),
        .i_clear         (w_restart),
        .i_rtp_timestamp (r_in.rtp_timestamp),
        .i_arrival_time  (r_in.arrival_time),
        .o_jitter        (w_jitter)
    );

    // The interval loss times 256 wraps modulo 2^32 before the divide.
    rtprs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_lost_int[23:0], 8'b0}),
        .i_divisor  (r_exp_int),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/rtprs_div.sv =====
// Bit-serial restoring divider for the fraction-lost report field.
// Depends on rtprs_pkg; returns the low 8 quotient bits once every dividend bit is shifted in.
module rtprs_div
    import rtprs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [7:0]  o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_dsr;
    logic [7:0]  r_quo;

    logic [32:0] w_shift;
    logic [32:0] w_trial;
    logic        w_ge;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign w_shift = {r_rem, r_dvd[31]};
    assign w_trial = w_shift - {1'b0, r_dsr};
    assign w_ge    = !w_trial[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[31:0] : w_shift[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_quo <= {r_quo[6:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hdl/rtprs_jitter.sv =====
// Interarrival jitter estimator, one arithmetic step per cycle.
// Depends on rtprs_pkg for the step strobes and the rounding constant.
module rtprs_jitter
    import rtprs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_jit_ctl    i_ctl,
    input  logic        i_clear,
    input  logic [31:0] i_rtp_timestamp,
    input  logic [31:0] i_arrival_time,
    output logic [27:0] o_jitter
);

    logic [31:0] r_last;
    logic [31:0] r_acc;
    logic [31:0] r_transit;
    logic [31:0] r_decay;
    logic [31:0] r_diff;
    logic [31:0] r_base;
    logic [31:0] r_mag;
    logic        r_prev_zero;

    logic [31:0] w_round;

    assign w_round = r_acc + JIT_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_acc  <= '0;
        end else if (i_ctl.commit) begin
            // A resync or the end of probation wipes what this packet just wrote.
            if (i_clear) begin
                r_last <= '0;
                r_acc  <= '0;
            end else begin
                r_last <= r_transit;
                if (!r_prev_zero) begin
                    r_acc <= r_base + r_mag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_transit <= i_arrival_time - i_rtp_timestamp;
            r_decay   <= {4'b0, w_round[31:4]};
        end
        if (i_ctl.diff) begin
            r_diff      <= r_transit - r_last;
            r_prev_zero <= (r_last == 32'd0);
            r_base      <= r_acc - r_decay;
        end
        if (i_ctl.mag) begin
            r_mag <= r_diff[31] ? (32'd0 - r_diff) : r_diff;
        end
    end

    assign o_jitter = r_acc[31:4];

endmodule

// ===== hdl/rtprs_seq.sv =====
// Sequence number validation: probation, dropout, misorder, wrap count and resync.
// Depends on rtprs_pkg; also keeps the interval counters that reports update.
module rtprs_seq
    import rtprs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit,
    input  logic [15:0] i_seq,
    input  logic [15:0] i_dropout_lim,
    input  logic [15:0] i_misorder_lim,
    input  logic        i_rep_commit,
    input  logic [31:0] i_rep_expected,
    output t_seq_stats  o_stats,
    output logic        o_accepted,
    output logic        o_restart
);

    logic [15:0] r_highest, n_highest;
    logic        r_probation, n_probation;
    logic [15:0] r_wrap, n_wrap;
    logic [31:0] r_base, n_base;
    logic [16:0] r_bad_seq, n_bad_seq;
    logic [31:0] r_received, n_received;
    logic [31:0] r_prior_exp, n_prior_exp;
    logic [31:0] r_prior_rec, n_prior_rec;
    logic        r_accepted, n_accepted;
    logic        r_restart, n_restart;

    logic [15:0] w_udelta;
    logic        w_restart;

    assign w_udelta = i_seq - r_highest;

    always_comb begin
        n_highest   = r_highest;
        n_probation = r_probation;
        n_wrap      = r_wrap;
        n_base      = r_base;
        n_bad_seq   = r_bad_seq;
        n_received  = r_received + 32'd1;
        n_prior_exp = r_prior_exp;
        n_prior_rec = r_prior_rec;
        n_accepted  = 1'b1;
        w_restart   = 1'b0;

        if (r_probation) begin
            // The compare against highest+1 is done at 17 bits so it never wraps.
            if ({1'b0, i_seq} == ({1'b0, r_highest} + 17'd1)) begin
                n_probation = 1'b0;
                w_restart   = 1'b1;
            end else begin
                n_highest = i_seq;
            end
        end else if (w_udelta < i_dropout_lim) begin
            if (i_seq < r_highest) begin
                n_wrap = r_wrap + 16'd1;
            end
            n_highest = i_seq;
        end else if ({1'b0, w_udelta} <= (SEQ_MOD - {1'b0, i_misorder_lim})) begin
            if ({1'b0, i_seq} == r_bad_seq) begin
                w_restart = 1'b1;
            end else begin
                n_bad_seq  = {1'b0, i_seq + 16'd1};
                n_received = r_received;
                n_accepted = 1'b0;
            end
        end

        if (w_restart) begin
            n_highest   = i_seq;
            n_wrap      = '0;
            n_base      = {16'b0, i_seq} - 32'd1;
            n_bad_seq   = BAD_SEQ_NONE;
            n_received  = 32'd1;
            n_prior_exp = '0;
            n_prior_rec = '0;
        end
        n_restart = w_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest   <= '0;
            r_probation <= 1'b1;
            r_wrap      <= '0;
            r_base      <= '0;
            r_bad_seq   <= '0;
            r_received  <= '0;
            r_prior_exp <= '0;
            r_prior_rec <= '0;
            r_accepted  <= 1'b0;
            r_restart   <= 1'b0;
        end else if (i_commit) begin
            r_highest   <= n_highest;
            r_probation <= n_probation;
            r_wrap      <= n_wrap;
            r_base      <= n_base;
            r_bad_seq   <= n_bad_seq;
            r_received  <= n_received;
            r_prior_exp <= n_prior_exp;
            r_prior_rec <= n_prior_rec;
            r_accepted  <= n_accepted;
            r_restart   <= n_restart;
        end else if (i_rep_commit) begin
            r_prior_exp <= i_rep_expected;
            r_prior_rec <= r_received;
        end
    end

    assign o_stats.ext_max        = {r_wrap, r_highest};
    assign o_stats.seq_origin     = r_base;
    assign o_stats.received       = r_received;
    assign o_stats.prior_expected = r_prior_exp;
    assign o_stats.prior_received = r_prior_rec;
    assign o_accepted             = r_accepted;
    assign o_restart              = r_restart;

endmodule

// ===== hdl/rtprs_checker.sv =====
// Port-level checks for the RTP receiver statistics block, bound to its top level.
// Depends on rtprs_pkg and the assertion macros in rtp_receiver_statistics_defines.svh.
`include "rtp_receiver_statistics_defines.svh"

module rtprs_checker
    import rtprs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic w_report_zero;

    // High when every report field of the shown result is zero.
    assign w_report_zero = (o_out_data.ext_highest == 32'd0) &&
                           (o_out_data.cumulative_lost == 24'd0) &&
                           (o_out_data.fraction_lost == 8'd0) &&
                           (o_out_data.jitter_out == 28'd0);

    // A waiting result stays put until it is taken.
    `RTPRS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // An accepted packet result carries nothing but the accept flag.
    `RTPRS_ASSERT_NOW(a_pkt_fields, o_out_valid && o_out_data.accepted, w_report_zero, "packet result with report fields")

    // One request at a time: the block is busy right after taking one.
    `RTPRS_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

endmodule

bind rtp_receiver_statistics rtprs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the RTP receiver statistics block.
// Depends on rtprs_pkg (request/result structs, codes, constants) and the block itself.
`timescale 1ns / 1ps

module tb_top
    import rtprs_pkg::*;
();

    localparam int STALL_LIMIT    = 4000;  // cycles with no handshake or bus access before giving up
    localparam int SETTLE_CYCLES  = 48;    // longer than the slowest report
    localparam int RAND_PER_PHASE = 20;
    localparam int BURST_PACKETS  = 270;
    localparam int DIR_ROWS       = 24;

    localparam logic [2:0] ADDR_DROPOUT  = {REG_DROPOUT, 2'b00};
    localparam logic [2:0] ADDR_MISORDER = {REG_MISORDER, 2'b00};

    localparam t_out_item ALL_ZERO    = '0;
    localparam t_out_item ACCEPT_ONLY = '{1'b1, 32'd0, 24'd0, 8'd0, 28'd0};

    // One row of the directed table. Rows with a typed result push that result as the
    // expectation; the others push what the predictor computes.
    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtp_receiver_statistics uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    // Predicted copy of the configuration and of the RFC 3550 source state.
    logic [15:0] cfg_dropout  = DROPOUT_RESET;
    logic [15:0] cfg_misorder = MISORDER_RESET;
    logic [15:0] st_highest   = '0;
    logic        st_probation = 1'b1;
    logic [15:0] st_wraps     = '0;
    logic [31:0] st_base      = '0;
    logic [16:0] st_pending   = '0;
    logic [31:0] st_received  = '0;
    logic [31:0] st_prior_exp = '0;
    logic [31:0] st_prior_rcv = '0;
    logic [31:0] st_jitter    = '0;
    logic [31:0] st_transit   = '0;

    // Expected results, oldest first, and the failure count.
    t_out_item expected_stats[$];
    int        mismatch_count = 0;

    // When set, neither side idles; toggled in stretches by the stimulus.
    bit steady = 1'b0;

    // Random stimulus bookkeeping: a large jump is usually followed by its
    // confirming packet so that resyncs happen often.
    bit          resync_due = 1'b0;
    logic [15:0] resync_seq;
    logic [31:0] rnd_ts;
    logic [31:0] path_delay;

    t_row dir_table [DIR_ROWS];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A resync or the end of probation starts the source over, jitter included.
    function automatic void restart_seq(logic [15:0] seq);
        st_highest   = seq;
        st_wraps     = '0;
        st_base      = {16'd0, seq} - 32'd1;
        st_pending   = BAD_SEQ_NONE;
        st_received  = '0;
        st_prior_exp = '0;
        st_prior_rcv = '0;
        st_jitter    = '0;
        st_transit   = '0;
    endfunction

    function automatic t_out_item predict_stats(t_in_item req);
        t_out_item   res;
        logic [31:0] transit;
        logic [31:0] prev;
        logic [31:0] diff;
        logic [31:0] mag;
        logic [15:0] seq;
        logic [15:0] udelta;
        logic [31:0] ext;
        logic [31:0] exp_total;
        logic [31:0] lost;
        logic [31:0] exp_int;
        logic [31:0] rec_int;
        logic [31:0] lost_int;
        logic [31:0] scaled;
        res = '0;
        seq = req.seq_number;
        if (req.opcode == OP_PACKET) begin
            // Jitter first; the magnitude of 0x80000000 stays 0x80000000.
            transit    = req.arrival_time - req.rtp_timestamp;
            prev       = st_transit;
            diff       = transit - prev;
            mag        = diff[31] ? (32'd0 - diff) : diff;
            st_transit = transit;
            if (prev != 32'd0)
                st_jitter = st_jitter + mag - ((st_jitter + JIT_ROUND) >> 4);

            udelta       = seq - st_highest;
            res.accepted = 1'b1;
            if (st_probation) begin
                // The compare does not wrap: highest 65535 never matches.
                if ({1'b0, seq} == {1'b0, st_highest} + 17'd1) begin
                    st_probation = 1'b0;
                    restart_seq(seq);
                end else begin
                    st_highest = seq;
                end
                st_received++;
            end else if (udelta < cfg_dropout) begin
                if (seq < st_highest)
                    st_wraps++;
                st_highest = seq;
                st_received++;
            end else if ({1'b0, udelta} <= SEQ_MOD - {1'b0, cfg_misorder}) begin
                if ({1'b0, seq} == st_pending) begin
                    restart_seq(seq);
                    st_received++;
                end else begin
                    st_pending   = {1'b0, seq + 16'd1};
                    res.accepted = 1'b0;
                end
            end else begin
                st_received++;
            end
        end else begin
            ext          = {st_wraps, st_highest};
            exp_total    = ext - st_base;
            lost         = exp_total - st_received;
            exp_int      = exp_total - st_prior_exp;
            rec_int      = st_received - st_prior_rcv;
            lost_int     = exp_int - rec_int;
            st_prior_exp = exp_total;
            st_prior_rcv = st_received;
            res.ext_highest     = ext;
            res.cumulative_lost = (lost > {8'd0, LOST_CLAMP}) ? LOST_CLAMP : lost[23:0];
            if (exp_int != 32'd0 && lost_int != 32'd0 && !lost_int[31]) begin
                // The shift wraps modulo 2^32 before the divide.
                scaled = (lost_int << 8) / exp_int;
                res.fraction_lost = scaled[7:0];
            end
            res.jitter_out = st_jitter[31:4];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    function automatic t_in_item packet_req(logic [15:0] seq, logic [31:0] ts,
                                            logic [31:0] arr);
        return '{OP_PACKET, seq, ts, arr};
    endfunction

    function automatic t_in_item report_req();
        return '{OP_REPORT, 16'd0, 32'd0, 32'd0};
    endfunction

    // Mostly well-formed traffic: small forward steps, resync pairs, reordered
    // packets and reports, with some noise in both sequence and timing.
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        int unsigned span;
        logic [15:0] seq;
        pick   = $urandom_range(0, 99);
        rnd_ts = rnd_ts + $urandom_range(0, 3000);
        r.opcode        = OP_PACKET;
        r.rtp_timestamp = rnd_ts;
        r.arrival_time  = rnd_ts + path_delay + $urandom_range(0, 200);
        if ($urandom_range(0, 19) == 0) begin
            r.rtp_timestamp = $urandom;
            r.arrival_time  = $urandom;
        end
        span = cfg_dropout - 16'd1;
        if (resync_due) begin
            seq        = resync_seq;
            resync_due = 1'b0;
        end else if (pick < 10) begin
            r.opcode = OP_REPORT;
            seq      = 16'($urandom);
        end else if (pick < 70) begin
            if ($urandom_range(0, 3) == 0 || span < 3)
                seq = st_highest + 16'($urandom_range(0, span));
            else
                seq = st_highest + 16'($urandom_range(0, 3));
        end else if (pick < 80) begin
            seq        = st_highest + cfg_dropout + 16'($urandom_range(0, 60000));
            resync_due = ($urandom_range(0, 4) != 0);
            resync_seq = seq + 16'd1;
        end else if (pick < 90) begin
            seq = st_highest - 16'($urandom_range(1, 150));
        end else begin
            seq = 16'($urandom);
        end
        r.seq_number = seq;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Waits a random gap, then holds the request until it is taken. The expectation
    // is pushed at the accepting edge, so the queue is always ahead of the results.
    task automatic issue_request(input t_in_item req, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_stats(req);
        expected_stats.push_back(typed ? want : predicted);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            issue_request(random_request(), 1'b0, ALL_ZERO);
        end
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only with the block idle: every result in, then a settle time.
    task automatic configure(input logic [15:0] dropout, input logic [15:0] misorder);
        i_in_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_write(ADDR_DROPOUT, {16'd0, dropout});
        apb_write(ADDR_MISORDER, {16'd0, misorder});
        cfg_dropout  = dropout;
        cfg_misorder = misorder;
        rnd_ts       = $urandom;
        path_delay   = $urandom;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic compare_stats(input t_out_item got);
        t_out_item want;
        if (expected_stats.size() == 0) begin
            report_mismatch("result with no request pending", got.ext_highest, 32'd0);
        end else begin
            want = expected_stats.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
            if (got.ext_highest !== want.ext_highest)
                report_mismatch("ext_highest", got.ext_highest, want.ext_highest);
            if (got.cumulative_lost !== want.cumulative_lost)
                report_mismatch("cumulative_lost", 32'(got.cumulative_lost),
                                32'(want.cumulative_lost));
            if (got.fraction_lost !== want.fraction_lost)
                report_mismatch("fraction_lost", 32'(got.fraction_lost),
                                32'(want.fraction_lost));
            if (got.jitter_out !== want.jitter_out)
                report_mismatch("jitter_out", 32'(got.jitter_out), 32'(want.jitter_out));
        end
    endtask

    // The receiver stalls a random number of cycles before each result, then
    // takes it. Ready is only rewritten once per step.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            compare_stats(o_out_data);
        end
    end

    // Watchdog: a run that stops moving is a failure.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rtp_receiver_statistics test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_in_item burst_req;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rnd_ts     = $urandom;
        path_delay = $urandom;

        // Directed part under the reset register values. Row groups: report straight
        // after reset, probation (including the non-wrapping compare at 65535), jitter
        // skip after a cleared transit, a transit step of exactly 2^31 both ways, a
        // large jump and its resync, reordered and duplicate packets, an unconfirmed
        // jump replaced by another, a sequence wrap, and back-to-back reports.
        dir_table = '{
            '{report_req(),                                   1'b1, ALL_ZERO},
            '{packet_req(16'hffff, 32'h0, 32'h0),             1'b1, ACCEPT_ONLY},
            '{packet_req(16'h0000, 32'hffffffff, 32'hffffffff), 1'b1, ACCEPT_ONLY},
            '{packet_req(16'd1, 32'd100, 32'd1100),           1'b1, ACCEPT_ONLY},
            '{packet_req(16'd2, 32'd200, 32'd1200),           1'b0, ALL_ZERO},
            '{packet_req(16'd3, 32'd300, 32'd1500),           1'b0, ALL_ZERO},
            '{packet_req(16'd4, 32'd0, 32'h800004b0),         1'b0, ALL_ZERO},
            '{packet_req(16'd5, 32'd400, 32'd1600),           1'b0, ALL_ZERO},
            '{packet_req(16'd6, 32'hffffffff, 32'h0),         1'b0, ALL_ZERO},
            '{report_req(),                                   1'b0, ALL_ZERO},
            '{packet_req(16'd3000, 32'd500, 32'd1700),        1'b0, ALL_ZERO},
            '{packet_req(16'd6000, 32'd600, 32'd1800),        1'b1, ALL_ZERO},
            '{packet_req(16'd6001, 32'd700, 32'd2000),        1'b0, ALL_ZERO},
            '{packet_req(16'd5990, 32'd800, 32'd2100),        1'b0, ALL_ZERO},
            '{packet_req(16'd6001, 32'd900, 32'd2150),        1'b0, ALL_ZERO},
            '{packet_req(16'd65000, 32'd1000, 32'd2300),      1'b1, ALL_ZERO},
            '{packet_req(16'd40000, 32'd1100, 32'd2400),      1'b1, ALL_ZERO},
            '{packet_req(16'd40001, 32'd1200, 32'd2500),      1'b0, ALL_ZERO},
            '{packet_req(16'd65000, 32'd1300, 32'd2600),      1'b1, ALL_ZERO},
            '{packet_req(16'd65001, 32'd1400, 32'd2700),      1'b0, ALL_ZERO},
            '{packet_req(16'd10, 32'd1500, 32'd2900),         1'b0, ALL_ZERO},
            '{packet_req(16'd20, 32'd1600, 32'd3000),         1'b0, ALL_ZERO},
            '{report_req(),                                   1'b0, ALL_ZERO},
            '{'{OP_REPORT, 16'hffff, 32'hffffffff, 32'hffffffff}, 1'b0, ALL_ZERO}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            issue_request(dir_table[r].req, dir_table[r].typed, dir_table[r].want);

        run_random(RAND_PER_PHASE);

        // Widest in-order window with a misorder window of zero. Steps of 65534 wrap
        // on nearly every packet, so the interval loss grows past 2^24: the loss
        // clamps and the scaled interval loss wraps before the divide. One step of
        // 65535 is then a large jump.
        configure(16'hffff, 16'h0000);
        steady = 1'b1;
        for (int b = 0; b < BURST_PACKETS; b++) begin
            burst_req = packet_req(st_highest - 16'd2, $urandom, $urandom);
            issue_request(burst_req, 1'b0, ALL_ZERO);
        end
        issue_request(packet_req(st_highest - 16'd1, $urandom, $urandom), 1'b0, ALL_ZERO);
        issue_request(report_req(), 1'b0, ALL_ZERO);
        steady = 1'b0;
        run_random(RAND_PER_PHASE);

        // Narrowest in-order window with the widest misorder window.
        configure(16'd1, 16'hffff);
        run_random(RAND_PER_PHASE);

        configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
        run_random(RAND_PER_PHASE);

        configure(16'hffff, 16'hffff);
        run_random(RAND_PER_PHASE);

        // Drain: every expectation met, then a settle time for stray results.
        i_in_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_stats.size() == 0)
            $display("rtp_receiver_statistics test passed");
        else
            $display("rtp_receiver_statistics test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rtprs_pkg.sv
hdl/rtprs_div.sv
hdl/rtprs_jitter.sv
hdl/rtprs_seq.sv
hdl/rtp_receiver_statistics.sv
hdl/rtprs_checker.sv
tb/tb_top.sv
